### src/hbn_pkg.sv
// ----------------------------------------------------------------------------
// hbn_pkg
// shared types, widths and codes of the histogram bin normalizer
// ----------------------------------------------------------------------------
package hbn_pkg;

  localparam int NUM_BINS = 64;
  localparam int BIN_W    = $clog2(NUM_BINS);

  localparam int LEN_W    = 16;
  localparam int WGT_W    = 24;
  localparam int CNT_W    = 32;
  localparam int IDX_O_W  = 6;
  localparam int CTR_O_W  = 17;
  localparam int FRAC_W   = 17;

  localparam int Q_W      = 17;
  localparam int STEP_W   = $clog2(Q_W + 1);
  localparam int PROD_W   = BIN_W + LEN_W;
  localparam int CTR_W    = BIN_W + LEN_W + 1;

  localparam logic [FRAC_W-1:0]  FRAC_ONE   = FRAC_W'(65536);
  localparam logic [CTR_O_W-1:0] CENTER_MAX = '1;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_LEN_MIN  = 2'd0;
  localparam logic [1:0] REG_LEN_MAX  = 2'd1;
  localparam logic [1:0] REG_BIN_SIZE = 2'd2;

  localparam logic [LEN_W-1:0] LEN_MIN_RST  = LEN_W'(100);
  localparam logic [LEN_W-1:0] LEN_MAX_RST  = LEN_W'(1000);
  localparam logic [LEN_W-1:0] BIN_SIZE_RST = LEN_W'(5);

  typedef struct packed {
    logic ld_sample;
    logic div_idx;
    logic chk;
    logic upd;
    logic scan_init;
    logic idx_inc;
    logic div_frac;
    logic emit;
    logic emit_empty;
  } hbn_cmd_t;

  typedef struct packed {
    logic in_range;
    logic div_done;
    logic idx_ovf;
    logic cur_touched;
    logic any_touched;
    logic last_bin;
    logic out_free;
  } hbn_sts_t;

endpackage

### src/hbn_div.sv
// ----------------------------------------------------------------------------
// hbn_div
// restoring divider, one quotient bit per cycle, fixed number of steps
// ----------------------------------------------------------------------------
module hbn_div
  import hbn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] rem_i,
  input  logic [Q_W-1:0]   bits_i,
  input  logic [CNT_W-1:0] dvs_i,
  output logic             busy_o,
  output logic [Q_W-1:0]   quo_o
);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [Q_W-1:0]    bits_q, bits_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [Q_W-1:0]    quo_q, quo_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              qbit;

  always_comb begin
    trial  = {rem_q, bits_q[Q_W-1]};
    diff   = trial - {1'b0, dvs_q};
    qbit   = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    bits_d = bits_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = rem_i;
      bits_d = bits_i;
      dvs_d  = dvs_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d  = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      bits_d = {bits_q[Q_W-2:0], 1'b0};
      quo_d  = {quo_q[Q_W-2:0], qbit};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(Q_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    bits_q <= bits_d;
    dvs_q  <= dvs_d;
    quo_q  <= quo_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

### src/hbn_dpath.sv
// ----------------------------------------------------------------------------
// hbn_dpath
// bin store, totals, divider and output register of the normalizer
// ----------------------------------------------------------------------------
module hbn_dpath
  import hbn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hbn_cmd_t             cmd_i,
  output hbn_sts_t             sts_o,
  input  logic [LEN_W-1:0]     len_min_i,
  input  logic [LEN_W-1:0]     len_max_i,
  input  logic [LEN_W-1:0]     bin_size_i,
  input  logic [LEN_W-1:0]     sample_length_i,
  input  logic [WGT_W-1:0]     sample_weight_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [IDX_O_W-1:0]   bin_index_o,
  output logic [CTR_O_W-1:0]   bin_center_o,
  output logic [CNT_W-1:0]     bin_total_o,
  output logic [FRAC_W-1:0]    fraction_o,
  output logic                 empty_res_o,
  output logic                 overflow_o,
  output logic                 last_o
);

  logic [CNT_W-1:0]    mem [NUM_BINS];
  logic [CNT_W-1:0]    rdata_q;

  logic [LEN_W-1:0]    len_q;
  logic [WGT_W-1:0]    wgt_q;
  logic [BIN_W-1:0]    idx_q, idx_d;
  logic [NUM_BINS-1:0] touched_q, touched_d;
  logic [CNT_W-1:0]    total_q, total_d;
  logic                ovf_q, ovf_d;

  logic                out_valid_q, out_valid_d;
  logic [IDX_O_W-1:0]  oidx_q;
  logic [CTR_O_W-1:0]  octr_q;
  logic [CNT_W-1:0]    ocnt_q;
  logic [FRAC_W-1:0]   frac_q;
  logic                empty_q;
  logic                oovf_q;
  logic                last_q;

  logic [LEN_W-1:0]    bs_eff;
  logic [LEN_W-1:0]    diff;
  logic                div_start;
  logic [CNT_W-1:0]    div_rem;
  logic [Q_W-1:0]      div_bits;
  logic [CNT_W-1:0]    div_dvs;
  logic                div_busy;
  logic [Q_W-1:0]      quo;
  logic [CNT_W-1:0]    cnt_eff;
  logic [CNT_W:0]      cnt_sum;
  logic [CNT_W:0]      tot_sum;
  logic [CNT_W-1:0]    new_cnt;
  logic [CNT_W-1:0]    new_total;
  logic [PROD_W-1:0]   prod;
  logic [CTR_W-1:0]    ctr_sum;
  logic [CTR_O_W-1:0]  center;
  logic [FRAC_W-1:0]   frac;
  logic [NUM_BINS-1:0] above;
  logic                out_free;
  logic                clear;

  assign bs_eff    = (bin_size_i == '0) ? LEN_W'(1) : bin_size_i;
  assign diff      = len_q - len_min_i;
  assign div_start = cmd_i.div_idx | cmd_i.div_frac;
  assign div_rem   = cmd_i.div_idx ? '0 : {1'b0, rdata_q[CNT_W-1:1]};
  assign div_bits  = cmd_i.div_idx ? {1'b0, diff} : {rdata_q[0], {(Q_W-1){1'b0}}};
  assign div_dvs   = cmd_i.div_idx ? {{(CNT_W-LEN_W){1'b0}}, bs_eff} : total_q;

  hbn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .bits_i  (div_bits),
    .dvs_i   (div_dvs),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  always_comb begin
    cnt_eff   = touched_q[idx_q] ? rdata_q : '0;
    cnt_sum   = {1'b0, cnt_eff} + (CNT_W+1)'(wgt_q);
    tot_sum   = {1'b0, total_q} + (CNT_W+1)'(wgt_q);
    new_cnt   = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
    new_total = tot_sum[CNT_W] ? '1 : tot_sum[CNT_W-1:0];
    prod      = PROD_W'(idx_q) * PROD_W'(bs_eff);
    ctr_sum   = CTR_W'(len_min_i) + CTR_W'(prod) + CTR_W'(bs_eff >> 1);
    center    = (ctr_sum > CTR_W'(CENTER_MAX)) ? CENTER_MAX : ctr_sum[CTR_O_W-1:0];
    if (total_q == '0) begin
      frac = '0;
    end else if (quo > FRAC_ONE) begin
      frac = FRAC_ONE;
    end else begin
      frac = quo;
    end
    for (int k = 0; k < NUM_BINS; k++) begin
      above[k] = (BIN_W'(k) > idx_q);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign clear    = (cmd_i.emit && sts_o.last_bin) || cmd_i.emit_empty;

  assign sts_o.in_range    = (len_q >= len_min_i) && (len_q < len_max_i);
  assign sts_o.div_done    = !div_busy;
  assign sts_o.idx_ovf     = (quo >= Q_W'(NUM_BINS));
  assign sts_o.cur_touched = touched_q[idx_q];
  assign sts_o.any_touched = |touched_q;
  assign sts_o.last_bin    = ~|(touched_q & above);
  assign sts_o.out_free    = out_free;

  always_comb begin
    idx_d       = idx_q;
    touched_d   = touched_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit || cmd_i.emit_empty) begin
      out_valid_d = 1'b1;
    end
    if (cmd_i.chk) begin
      if (sts_o.idx_ovf) begin
        ovf_d = 1'b1;
      end else begin
        idx_d = quo[BIN_W-1:0];
      end
    end
    if (cmd_i.scan_init) begin
      idx_d = '0;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + BIN_W'(1);
    end
    if (cmd_i.upd) begin
      touched_d[idx_q] = 1'b1;
      total_d          = new_total;
    end
    if (clear) begin
      touched_d = '0;
      total_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      touched_q   <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      touched_q   <= touched_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      mem[idx_q] <= new_cnt;
    end
    rdata_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_sample) begin
      len_q <= sample_length_i;
      wgt_q <= sample_weight_i;
    end
    if (cmd_i.emit) begin
      oidx_q  <= IDX_O_W'(idx_q);
      octr_q  <= center;
      ocnt_q  <= rdata_q;
      frac_q  <= frac;
      empty_q <= 1'b0;
      oovf_q  <= ovf_q;
      last_q  <= sts_o.last_bin;
    end else if (cmd_i.emit_empty) begin
      oidx_q  <= '0;
      octr_q  <= '0;
      ocnt_q  <= '0;
      frac_q  <= '0;
      empty_q <= 1'b1;
      oovf_q  <= ovf_q;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bin_index_o  = oidx_q;
  assign bin_center_o = octr_q;
  assign bin_total_o  = ocnt_q;
  assign fraction_o   = frac_q;
  assign empty_res_o  = empty_q;
  assign overflow_o   = oovf_q;
  assign last_o       = last_q;

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && empty_q |-> last_q)
    else $error("empty result without last");

  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> frac_q <= FRAC_ONE)
    else $error("fraction above one");

  a_cnt_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |-> new_cnt <= new_total)
    else $error("bin count exceeds total");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (touched_q == '0) && (total_q == '0))
    else $error("store not cleared after finish");

endmodule

### src/hbn_ctrl.sv
// ----------------------------------------------------------------------------
// hbn_ctrl
// sequencer for sample loading and the finish scan
// ----------------------------------------------------------------------------
module hbn_ctrl
  import hbn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     cmd_i,
  output logic     in_ready_o,
  input  hbn_sts_t sts_i,
  output hbn_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_CHK,
    S_RD,
    S_UPD,
    S_SCAN,
    S_FRD,
    S_FDIV,
    S_EMIT,
    S_EMPTY
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cmd_i == CMD_ADD) begin
            cmd_o.ld_sample = 1'b1;
            state_d         = S_PREP;
          end else if (sts_i.any_touched) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end else begin
            state_d = S_EMPTY;
          end
        end
      end
      S_PREP: begin
        if (sts_i.in_range) begin
          cmd_o.div_idx = 1'b1;
          state_d       = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = sts_i.idx_ovf ? S_IDLE : S_RD;
      end
      S_RD: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_IDLE;
      end
      S_SCAN: begin
        if (sts_i.cur_touched) begin
          state_d = S_FRD;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_FRD: begin
        cmd_o.div_frac = 1'b1;
        state_d        = S_FDIV;
      end
      S_FDIV: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_bin) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_SCAN;
          end
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_div_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK || state_q == S_EMIT) |-> sts_i.div_done)
    else $error("divider busy when result used");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit || cmd_o.emit_empty) |-> sts_i.out_free)
    else $error("result loaded over pending item");

  a_scan_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRD) |-> sts_i.cur_touched)
    else $error("scan stopped on untouched bin");

endmodule

### src/histogram_bin_normalizer_top.sv
// A sample item (cmd 0) passes a capture and range check, a 17-step
// restoring division of the offset by the bin width that holds the
// sequencer, then a read and a saturating write of the single-port bin
// store. Items outside the length range return after the range check, bins
// beyond the store after the division. A finish item (cmd 1) walks the bin
// indexes one per cycle; each touched bin holds the walk while the same
// divider computes its Q1.16 share of the total and during any wait on the
// output side. One result is held in an output register, so the next item is
// taken while the last result waits. An empty finish returns a single result
// flagged empty_res. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// histogram_bin_normalizer_top
// weighted length histogram with normalized bin output
// ----------------------------------------------------------------------------
module histogram_bin_normalizer_top
  import hbn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [LEN_W-1:0]   sample_length_i,
  input  logic [WGT_W-1:0]   sample_weight_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IDX_O_W-1:0] bin_index_o,
  output logic [CTR_O_W-1:0] bin_center_o,
  output logic [CNT_W-1:0]   bin_total_o,
  output logic [FRAC_W-1:0]  fraction_o,
  output logic               empty_res_o,
  output logic               overflow_o,
  output logic               last_o
);

  logic [LEN_W-1:0] len_min_q;
  logic [LEN_W-1:0] len_max_q;
  logic [LEN_W-1:0] bin_size_q;
  logic             wr_en;
  logic [1:0]       reg_sel;
  hbn_cmd_t         cmd;
  hbn_sts_t         sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_min_q  <= LEN_MIN_RST;
      len_max_q  <= LEN_MAX_RST;
      bin_size_q <= BIN_SIZE_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_LEN_MIN:  len_min_q  <= pwdata[LEN_W-1:0];
        REG_LEN_MAX:  len_max_q  <= pwdata[LEN_W-1:0];
        REG_BIN_SIZE: bin_size_q <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LEN_MIN:  prdata = {{(32-LEN_W){1'b0}}, len_min_q};
      REG_LEN_MAX:  prdata = {{(32-LEN_W){1'b0}}, len_max_q};
      REG_BIN_SIZE: prdata = {{(32-LEN_W){1'b0}}, bin_size_q};
      default:      prdata = '0;
    endcase
  end

  hbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hbn_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .len_min_i       (len_min_q),
    .len_max_i       (len_max_q),
    .bin_size_i      (bin_size_q),
    .sample_length_i (sample_length_i),
    .sample_weight_i (sample_weight_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .bin_index_o     (bin_index_o),
    .bin_center_o    (bin_center_o),
    .bin_total_o     (bin_total_o),
    .fraction_o      (fraction_o),
    .empty_res_o     (empty_res_o),
    .overflow_o      (overflow_o),
    .last_o          (last_o)
  );

endmodule

### tb/sv/histogram_bin_normalizer_top_tb.sv
// ----------------------------------------------------------------------------
// histogram_bin_normalizer_top_tb
// drives weighted length samples and finish items into the histogram block,
// predicts every emitted bin record in step with accepted items and checks the
// output stream field by field, with random idling on both sides
// ----------------------------------------------------------------------------
module histogram_bin_normalizer_top_tb;
  import hbn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic             cmd;
    logic [LEN_W-1:0] len;
    logic [WGT_W-1:0] wgt;
  } sample_item_t;

  typedef struct packed {
    logic [IDX_O_W-1:0] index;
    logic [CTR_O_W-1:0] center;
    logic [CNT_W-1:0]   total;
    logic [FRAC_W-1:0]  share;
    logic               empty;
    logic               ovf;
    logic               last;
  } bin_report_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               cmd_i = CMD_ADD;
  logic [LEN_W-1:0]   sample_length_i = '0;
  logic [WGT_W-1:0]   sample_weight_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [IDX_O_W-1:0] bin_index_o;
  logic [CTR_O_W-1:0] bin_center_o;
  logic [CNT_W-1:0]   bin_total_o;
  logic [FRAC_W-1:0]  fraction_o;
  logic               empty_res_o;
  logic               overflow_o;
  logic               last_o;

  // predictor state
  logic [LEN_W-1:0] cfg_len_min = LEN_MIN_RST;
  logic [LEN_W-1:0] cfg_len_max = LEN_MAX_RST;
  logic [LEN_W-1:0] cfg_bin_size = BIN_SIZE_RST;
  logic [CNT_W-1:0] bin_count [NUM_BINS];
  bit               bin_hit [NUM_BINS];
  logic [CNT_W-1:0] grand_sum = '0;
  bit               ovf_seen = 1'b0;

  sample_item_t sample_backlog [$];
  bin_report_t  bins_due [$];
  sample_item_t next_item;
  bin_report_t  due_head;

  bit holding = 1'b0;
  bit in_taken = 1'b0;
  bit gaps_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int fail_count = 0;

  histogram_bin_normalizer_top uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      flag_error($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  function automatic logic [CNT_W-1:0] sat_sum(logic [CNT_W-1:0] a, logic [WGT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(b);
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  function automatic void histogram_apply(logic cmd, logic [LEN_W-1:0] len,
                                          logic [WGT_W-1:0] wgt);
    bin_report_t     rep;
    bin_report_t     held;
    bit              have_held;
    int unsigned     bs;
    int unsigned     idx;
    int unsigned     center;
    longint unsigned share;
    bs = (cfg_bin_size == 0) ? 1 : cfg_bin_size;
    if (cmd == CMD_ADD) begin
      if (len < cfg_len_min || len >= cfg_len_max) return;
      idx = (len - cfg_len_min) / bs;
      if (idx >= NUM_BINS) begin
        ovf_seen = 1'b1;
        return;
      end
      bin_count[idx] = sat_sum(bin_count[idx], wgt);
      bin_hit[idx] = 1'b1;
      grand_sum = sat_sum(grand_sum, wgt);
      return;
    end
    have_held = 1'b0;
    for (int i = 0; i < NUM_BINS; i++) begin
      if (bin_hit[i]) begin
        center = cfg_len_min + i * bs + bs / 2;
        if (center > 131071) center = 131071;
        share = 0;
        if (grand_sum != 0) begin
          share = (longint'(bin_count[i]) << 16) / grand_sum;
          if (share > 65536) share = 65536;
        end
        rep.index = IDX_O_W'(i);
        rep.center = CTR_O_W'(center);
        rep.total = bin_count[i];
        rep.share = FRAC_W'(share);
        rep.empty = 1'b0;
        rep.ovf = ovf_seen;
        rep.last = 1'b0;
        if (have_held) bins_due.insert(bins_due.size(), held);
        held = rep;
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      bins_due.insert(bins_due.size(), held);
    end else begin
      rep = '0;
      rep.empty = 1'b1;
      rep.last = 1'b1;
      rep.ovf = ovf_seen;
      bins_due.insert(bins_due.size(), rep);
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      bin_count[i] = '0;
      bin_hit[i] = 1'b0;
    end
    grand_sum = '0;
  endfunction

  // item acceptance and result checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        histogram_apply(cmd_i, sample_length_i, sample_weight_i);
        in_taken = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        if (bins_due.size() == 0) begin
          flag_error($sformatf("result with none due, bin %0d", bin_index_o));
        end else begin
          due_head = bins_due.pop_front();
          check_field("bin_index", 32'(due_head.index), 32'(bin_index_o));
          check_field("bin_center", 32'(due_head.center), 32'(bin_center_o));
          check_field("bin_total", due_head.total, bin_total_o);
          check_field("fraction", 32'(due_head.share), 32'(fraction_o));
          check_field("empty_res", 32'(due_head.empty), 32'(empty_res_o));
          check_field("overflow", 32'(due_head.ovf), 32'(overflow_o));
          check_field("last", 32'(due_head.last), 32'(last_o));
        end
      end
    end
  end

  // sample driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        holding = 1'b0;
        if (gaps_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 11);
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          next_item = sample_backlog.pop_front();
          cmd_i <= next_item.cmd;
          sample_length_i <= next_item.len;
          sample_weight_i <= next_item.wgt;
          in_valid_i <= 1'b1;
          holding = 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_register(logic [1:0] reg_idx, logic [LEN_W-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({reg_idx, 2'b00});
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("register readback", 32'(value), prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (reg_idx)
      REG_LEN_MIN:  cfg_len_min = value;
      REG_LEN_MAX:  cfg_len_max = value;
      REG_BIN_SIZE: cfg_bin_size = value;
      default: ;
    endcase
  endtask

  task automatic push_item(logic cmd, logic [LEN_W-1:0] len, logic [WGT_W-1:0] wgt);
    sample_item_t it;
    it.cmd = cmd;
    it.len = len;
    it.wgt = wgt;
    sample_backlog.insert(sample_backlog.size(), it);
  endtask

  task automatic push_finish();
    push_item(CMD_FINISH, LEN_W'($urandom()), WGT_W'($urandom()));
  endtask

  // no result is due and the block has had time to finish a trailing sample
  task automatic wait_drained();
    while (sample_backlog.size() != 0 || holding || bins_due.size() != 0)
      @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic run_mixed(int n);
    int unsigned r;
    logic [LEN_W-1:0] len;
    logic [WGT_W-1:0] wgt;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
        0:       wgt = '0;
        1:       wgt = '1;
        2, 3:    wgt = WGT_W'($urandom());
        default: wgt = WGT_W'($urandom_range(1, 1000));
      endcase
      if (r < 8) begin
        push_finish();
      end else if (r < 18) begin
        push_item(logic'($urandom_range(0, 1)), LEN_W'($urandom()), WGT_W'($urandom()));
      end else begin
        if (cfg_len_max > cfg_len_min)
          len = LEN_W'($urandom_range(cfg_len_min, cfg_len_max - 1));
        else len = LEN_W'($urandom());
        push_item(CMD_ADD, len, wgt);
      end
    end
    push_finish();
  endtask

  initial begin
    int unsigned bs;
    int unsigned lo;
    int unsigned hi;
    for (int i = 0; i < NUM_BINS; i++) begin
      bin_count[i] = '0;
      bin_hit[i] = 1'b0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: edges of the range, store limit, zero weight
    push_finish();
    push_item(CMD_ADD, 16'd99, 24'd5);
    push_item(CMD_ADD, 16'd1000, 24'd5);
    push_item(CMD_ADD, 16'd100, 24'd0);
    push_item(CMD_ADD, 16'd419, 24'hFFFFFF);
    push_item(CMD_ADD, 16'd420, 24'd1);
    push_item(CMD_ADD, 16'hFFFF, 24'hFFFFFF);
    push_item(CMD_ADD, 16'd0, 24'd3);
    push_item(CMD_ADD, 16'd200, 24'd12345);
    push_finish();
    push_finish();
    wait_drained();

    // empty length range
    write_register(REG_LEN_MIN, 16'hFFFF);
    write_register(REG_LEN_MAX, 16'd0);
    write_register(REG_BIN_SIZE, 16'hFFFF);
    push_item(CMD_ADD, 16'hFFFF, 24'd9);
    push_item(CMD_ADD, 16'd0, 24'd9);
    push_finish();
    wait_drained();

    // bin width zero behaves as one
    write_register(REG_LEN_MIN, 16'd0);
    write_register(REG_LEN_MAX, 16'hFFFF);
    write_register(REG_BIN_SIZE, 16'd0);
    push_item(CMD_ADD, 16'd0, 24'd7);
    push_item(CMD_ADD, 16'd63, 24'd1);
    push_item(CMD_ADD, 16'd64, 24'd1);
    push_item(CMD_ADD, 16'hFFFF, 24'd5);
    push_item(CMD_ADD, 16'hFFFE, 24'd5);
    push_finish();
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      bs = (ph == 0) ? 1 : $urandom_range(2, 40);
      lo = $urandom_range(0, 3000);
      hi = lo + bs * $urandom_range(20, 90);
      if (hi > 65535) hi = 65535;
      write_register(REG_BIN_SIZE, LEN_W'(bs));
      write_register(REG_LEN_MIN, LEN_W'(lo));
      write_register(REG_LEN_MAX, LEN_W'(hi));
      run_mixed(35);
      wait_drained();
    end

    // one wide bin driven into saturation of its count and the total
    write_register(REG_LEN_MIN, 16'd0);
    write_register(REG_LEN_MAX, 16'hFFFF);
    write_register(REG_BIN_SIZE, 16'hFFFF);
    for (int k = 0; k < 270; k++) begin
      if ($urandom_range(0, 19) == 0)
        push_item(CMD_ADD, LEN_W'($urandom()), WGT_W'($urandom()));
      else
        push_item(CMD_ADD, LEN_W'($urandom_range(0, 65534)),
                  WGT_W'($urandom_range(24'hFFFFFF, 24'hFC0000)));
    end
    push_finish();
    wait_drained();

    gaps_on = 1'b0;
    write_register(REG_LEN_MIN, LEN_MIN_RST);
    write_register(REG_LEN_MAX, LEN_MAX_RST);
    write_register(REG_BIN_SIZE, BIN_SIZE_RST);
    run_mixed(40);
    wait_drained();

    if (fail_count == 0 && bins_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
